// ----- rtl/core/sftfp_pkg.sv -----
// Shared types and constants for the signed fraction to fixed-point divider.
package sftfp_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned INT_BITS      = 31;
  localparam int unsigned QUOT_W        = 57;
  localparam int unsigned FRAC_BITS_DEF = 24;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_INT_OVF  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } in_t;

  typedef struct packed {
    logic signed [QUOT_W-1:0] quotient;
    status_e                  status;
  } out_t;

  // Partial remainder plus everything that rides along with it.
  typedef struct packed {
    logic [DATA_W-1:0]   rem;
    logic [DATA_W-1:0]   den;
    logic [INT_BITS-1:0] num_lo;
    logic                neg;
    status_e             status;
  } div_state_t;

endpackage

// ----- rtl/core/sftfp_prep.sv -----
// Front end: operand magnitudes, zero check and integer overflow check.
module sftfp_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  sftfp_pkg::in_t          data_i,
  output logic                    valid_o,
  output sftfp_pkg::div_state_t   state_o
);
  import sftfp_pkg::*;

  logic [DATA_W-1:0] num_bits, den_bits, num_mag, den_mag;
  logic              v1_q, v2_q;
  logic [DATA_W-1:0] a_q, b_q;
  logic              neg_q, zero_q;
  logic              ovf;
  div_state_t        state_d, state_q;

  always_comb begin
    num_bits = data_i.numerator;
    den_bits = data_i.denominator;
    num_mag  = num_bits[DATA_W-1] ? (~num_bits) + DATA_W'(1) : num_bits;
    den_mag  = den_bits[DATA_W-1] ? (~den_bits) + DATA_W'(1) : den_bits;
  end

  // quotient >= 2^31 exactly when floor(a / 2^31) >= b
  always_comb begin
    ovf            = {{INT_BITS{1'b0}}, a_q[DATA_W-1:INT_BITS]} >= b_q;
    state_d.rem    = {{INT_BITS{1'b0}}, a_q[DATA_W-1:INT_BITS]};
    state_d.den    = b_q;
    state_d.num_lo = a_q[INT_BITS-1:0];
    state_d.neg    = neg_q;
    if (zero_q) begin
      state_d.status = ST_DIV_ZERO;
    end else if (ovf) begin
      state_d.status = ST_INT_OVF;
    end else begin
      state_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= num_mag;
      b_q     <= den_mag;
      neg_q   <= num_bits[DATA_W-1] ^ den_bits[DATA_W-1];
      zero_q  <= den_bits == '0;
      state_q <= state_d;
    end
  end

  assign valid_o = v2_q;
  assign state_o = state_q;

endmodule

// ----- rtl/core/sftfp_div_stage.sv -----
// One restoring-division step: shift in a dividend bit, compare, subtract.
module sftfp_div_stage #(
  parameter int unsigned QuotN = sftfp_pkg::INT_BITS + sftfp_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  sftfp_pkg::div_state_t   state_i,
  input  logic [QuotN-1:0]        quot_i,
  output logic                    valid_o,
  output sftfp_pkg::div_state_t   state_o,
  output logic [QuotN-1:0]        quot_o
);
  import sftfp_pkg::*;

  logic [DATA_W-1:0] shifted;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic              valid_q;
  div_state_t        state_d, state_q;
  logic [QuotN-1:0]  quot_d, quot_q;

  // num_lo runs dry after the integer steps, so fraction steps shift in zeros
  always_comb begin
    shifted        = {state_i.rem[DATA_W-2:0], state_i.num_lo[INT_BITS-1]};
    diff           = {1'b0, shifted} - {1'b0, state_i.den};
    ge             = ~diff[DATA_W];
    state_d        = state_i;
    state_d.rem    = ge ? diff[DATA_W-1:0] : shifted;
    state_d.num_lo = {state_i.num_lo[INT_BITS-2:0], 1'b0};
    quot_d         = {quot_i[QuotN-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      quot_q  <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign quot_o  = quot_q;

endmodule

// ----- rtl/core/sftfp_finish.sv -----
// Back end: round-half-away-from-zero decision, sign application and error zeroing.
module sftfp_finish #(
  parameter int unsigned FracBits = sftfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  sftfp_pkg::div_state_t                     state_i,
  input  logic [sftfp_pkg::INT_BITS+FracBits-1:0]   quot_i,
  output logic                                      valid_o,
  output sftfp_pkg::out_t                           data_o
);
  import sftfp_pkg::*;

  localparam int unsigned QuotN = INT_BITS + FracBits;
  localparam int unsigned ResW  = (QuotN + 2 > QUOT_W) ? QuotN + 2 : QUOT_W;

  logic             rnd_d;
  logic             valid_q, rnd_q, neg_q;
  logic [QuotN-1:0] mag_q;
  status_e          status_q;
  logic [ResW-1:0]  mag_x, rnd_x, res;

  assign rnd_d = {state_i.rem[DATA_W-2:0], 1'b0} >= state_i.den;

  // -(m + r) == ~m + (1 - r): one adder covers both signs
  always_comb begin
    mag_x = {{(ResW-QuotN){1'b0}}, mag_q};
    if (neg_q) begin
      rnd_x = {{(ResW-1){1'b0}}, ~rnd_q};
      res   = (~mag_x) + rnd_x;
    end else begin
      rnd_x = {{(ResW-1){1'b0}}, rnd_q};
      res   = mag_x + rnd_x;
    end
    data_o.status   = status_q;
    data_o.quotient = (status_q == ST_OK) ? res[QUOT_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q    <= rnd_d;
      neg_q    <= state_i.neg;
      mag_q    <= quot_i;
      status_q <= state_i.status;
    end
  end

  assign valid_o = valid_q;

endmodule

// ----- rtl/core/sftfp_out_buf.sv -----
// Two-entry output buffer; its fill level gates the whole pipeline.
module sftfp_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sftfp_pkg::out_t data_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sftfp_pkg::out_t out_data_o
);
  import sftfp_pkg::*;

  out_t       buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = buf_q[rd_q];
  assign space_o     = cnt_q != 2'd2;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/signed_fraction_to_fixed_point_unit.sv -----
// Top level: pipelined signed 64-bit division into a rounded fixed-point quotient.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (numerator, denominator)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (quotient, status)
//
// One transaction per cycle sustained while the output buffer has room; one restoring
// step per stage over 31 integer and FRAC_BITS fraction bits.
// Reset clears valid bits and the output buffer only; datapath registers are unreset.
// All stages advance together while the two-entry output buffer has room, so a
// transaction is accepted while one result waits; a full buffer freezes the pipe.
module signed_fraction_to_fixed_point_unit #(
  parameter int unsigned FRAC_BITS = sftfp_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sftfp_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sftfp_pkg::out_t out_data_o
);
  import sftfp_pkg::*;

  localparam int unsigned QuotN = INT_BITS + FRAC_BITS;

  logic             en;
  logic             vl [QuotN+1];
  div_state_t       st [QuotN+1];
  logic [QuotN-1:0] qt [QuotN+1];
  logic             fin_valid;
  out_t             fin_data;

  assign in_ready_o = en;

  sftfp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (vl[0]),
    .state_o (st[0])
  );

  assign qt[0] = '0;

  for (genvar k = 0; k < QuotN; k++) begin : g_step
    sftfp_div_stage #(
      .QuotN (QuotN)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vl[k]),
      .state_i (st[k]),
      .quot_i  (qt[k]),
      .valid_o (vl[k+1]),
      .state_o (st[k+1]),
      .quot_o  (qt[k+1])
    );
  end

  sftfp_finish #(
    .FracBits (FRAC_BITS)
  ) u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vl[QuotN]),
    .state_i (st[QuotN]),
    .quot_i  (qt[QuotN]),
    .valid_o (fin_valid),
    .data_o  (fin_data)
  );

  sftfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && fin_valid),
    .data_i      (fin_data),
    .space_o     (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
